### rtl/mexp_pkg.sv
package mexp_pkg;

	// port widths are fixed by the item format
	localparam int unsigned DATA_W            = 64;
	localparam int unsigned OPERAND_WIDTH_DEF = 64;

	// configuration register map
	localparam int unsigned CFG_IDX_W    = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

	// handshake between sequencer and multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

### rtl/modular_exponentiation.sv
// channel   dir  handshake                 payload
// config    in   cfg_write                 cfg_index, cfg_data (0 modulus, 1 exponent)
// input     in   in_valid / in_ready       base
// output    out  out_valid / out_ready     power
//
// One item first reduces the base (the multiplier starts in the accept cycle),
// then for each exponent bit up to the top set bit does one check, a multiply
// when the bit is set and a squaring, plus a last check and the hand-off; every
// product goes through the single shift-and-add modular multiplier.
// A modulus of zero skips the multiplier and finishes with power 0.
// Reset clears the key to modulus 1, exponent 1, and empties the output.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready holds the sequencer in its final state but not the computation.
module modular_exponentiation #(
	parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mexp_pkg::DATA_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mexp_pkg::DATA_W-1:0]    base,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mexp_pkg::DATA_W-1:0]    power
);
	import mexp_pkg::*;

	localparam int unsigned W = OPERAND_WIDTH;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;  // base mod m
	localparam logic [2:0] ST_CHECK  = 3'd2;  // look at next exponent bit
	localparam logic [2:0] ST_MULACC = 3'd3;  // acc * b mod m
	localparam logic [2:0] ST_SQUARE = 3'd4;  // b * b mod m
	localparam logic [2:0] ST_DONE   = 3'd5;  // hand result to output reg

	logic [DATA_W-1:0] modulus_q;
	logic [DATA_W-1:0] exponent_q;
	logic [2:0]        state_q;
	logic [W-1:0]      acc_q;     // running result
	logic [W-1:0]      rb_q;      // running base power
	logic [W-1:0]      e_q;       // exponent bits still to go
	logic [W-1:0]      power_q;
	logic              out_valid_q;

	logic [W-1:0] mod_w;
	logic [W-1:0] one_w;          // 1 mod m
	logic         in_acc;
	logic         out_free;

	logic         mul_start;
	logic [W-1:0] mul_x;
	logic [W-1:0] mul_y;
	logic [W-1:0] mul_prod;
	mul_stat_t    mul_stat;

	assign mod_w    = modulus_q[W-1:0];
	assign one_w    = (mod_w == W'(1)) ? '0 : W'(1);
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// config writes; the user must see that the key only changes while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= DATA_W'(1);
			exponent_q <= DATA_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_start = 1'b0;
		mul_x     = rb_q;
		mul_y     = rb_q;
		unique case (state_q)
			ST_IDLE: begin
				// reduce the base: (1 mod m) * base, base taken bit by bit
				mul_start = in_acc && (mod_w != '0);
				mul_x     = one_w;
				mul_y     = base[W-1:0];
			end
			ST_CHECK: begin
				mul_start = (e_q != '0);
				if (e_q[0]) begin
					mul_x = acc_q;
				end
			end
			ST_MULACC: begin
				// square starts as soon as the multiply lands
				mul_start = mul_stat.done;
			end
			default: ;
		endcase
	end

	mexp_modmul #(
		.W(W)
	) u_modmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.x     (mul_x),
		.y     (mul_y),
		.m     (mod_w),
		.stat  (mul_stat),
		.prod  (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (mod_w == '0) ? ST_DONE : ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (mul_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (e_q == '0) begin
						state_q <= ST_DONE;
					end else if (e_q[0]) begin
						state_q <= ST_MULACC;
					end else begin
						state_q <= ST_SQUARE;
					end
				end
				ST_MULACC: begin
					if (mul_stat.done) begin
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (mul_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					acc_q <= '0;  // stays 0 for a zero modulus
					e_q   <= exponent_q[W-1:0];
				end
			end
			ST_REDUCE: begin
				if (mul_stat.done) begin
					rb_q  <= mul_prod;
					acc_q <= one_w;
				end
			end
			ST_MULACC: begin
				if (mul_stat.done) begin
					acc_q <= mul_prod;
				end
			end
			ST_SQUARE: begin
				if (mul_stat.done) begin
					rb_q <= mul_prod;
					e_q  <= e_q >> 1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					power_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign power     = DATA_W'(power_q);

`ifndef NO_ASSERTIONS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier started while busy");
	a_done_in_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_REDUCE || state_q == ST_MULACC ||
		state_q == ST_SQUARE))
		else $error("multiplier finished outside a multiply state");
	a_operands_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (acc_q < mod_w) && (rb_q < mod_w))
		else $error("running values not reduced below modulus");
	a_done_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_free |=> out_valid_q && (state_q == ST_IDLE))
		else $error("result not handed to output register");
`endif

endmodule

### rtl/mexp_modmul.sv
module mexp_modmul #(
	parameter int unsigned W = mexp_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [W-1:0]         x,
	input  logic [W-1:0]         y,
	input  logic [W-1:0]         m,
	output mexp_pkg::mul_stat_t  stat,
	output logic [W-1:0]         prod
);
	import mexp_pkg::*;

	localparam int unsigned CNT_W = $clog2(W + 1);

	// (a + b) mod m for a, b < m; one carry bit kept
	function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
		input logic [W-1:0] md);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, md}) begin
			s = s - {1'b0, md};
		end
		return s[W-1:0];
	endfunction

	logic [W-1:0]     acc_q;
	logic [W-1:0]     x_q;
	logic [W-1:0]     y_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	// LSB-first: conditional add into acc and doubling of x, both in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
		end else if (cnt_q != '0) begin
			if (y_q[0]) begin
				acc_q <= add_mod(acc_q, x_q, m);
			end
			x_q <= add_mod(x_q, x_q, m);
			y_q <= y_q >> 1;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign prod      = acc_q;

`ifndef NO_ASSERTIONS
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (cnt_q == CNT_W'(W)) && !done_q)
		else $error("multiplier did not load its step count");
	a_prod_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (acc_q < m))
		else $error("product not reduced below modulus");
	a_done_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0))
		else $error("multiplier flagged done while still stepping");
`endif

endmodule
